// ----- rtl/packet_strobing_controller_assert.svh -----
// Assertion macros for the packet strobing controller.
`ifndef PACKET_STROBING_CONTROLLER_ASSERT_SVH
`define PACKET_STROBING_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSC_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("psc check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PSC_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("psc check failed");

`endif

// ----- rtl/psc_pkg.sv -----
// Shared types, codes and helper functions for the packet strobing controller.
`default_nettype none

package psc_pkg;

    // Protocol limits
    localparam int MAX_PAYLOAD    = 124;
    localparam int FRAME_OVERHEAD = 3;
    localparam int MAX_FRAME      = MAX_PAYLOAD + FRAME_OVERHEAD;
    localparam int CRC_OK_BIT     = 7;

    // Receive window: (len * WIN_SCALE + WIN_BASE) * WIN_TICKS
    localparam int WIN_SCALE = 35;
    localparam int WIN_BASE  = 200;
    localparam int WIN_TICKS = 4;

    // Event codes
    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_RISE  = 3'd2;
    localparam logic [2:0] REQ_FALL  = 3'd3;
    localparam logic [2:0] REQ_BYTE  = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;

    // Radio command codes
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_LISTEN   = 3'd1;
    localparam logic [2:0] CMD_TX       = 3'd2;
    localparam logic [2:0] CMD_OFF      = 3'd3;
    localparam logic [2:0] CMD_RELISTEN = 3'd4;

    // Reported protocol state codes
    localparam logic [2:0] PST_OFF      = 3'd0;
    localparam logic [2:0] PST_WAIT     = 3'd1;
    localparam logic [2:0] PST_RX       = 3'd2;
    localparam logic [2:0] PST_READY    = 3'd3;
    localparam logic [2:0] PST_TX       = 3'd4;
    localparam logic [2:0] PST_SENT     = 3'd5;
    localparam logic [2:0] PST_ABORT    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_INITIATOR = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD   = 2'd1;
    localparam logic [1:0] CFG_TX_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_HEADER    = 2'd3;

    // Error counter slots
    localparam int ERR_LEN = 0;
    localparam int ERR_HDR = 1;
    localparam int ERR_CRC = 2;
    localparam int ERR_TMO = 3;
    localparam int ERR_NUM = 4;

    // Internal protocol state, one-hot
    typedef enum logic [5:0] {
        ST_OFF   = 6'b000001,
        ST_WAIT  = 6'b000010,
        ST_RX    = 6'b000100,
        ST_READY = 6'b001000,
        ST_TX    = 6'b010000,
        ST_ABORT = 6'b100000
    } state_t;

    typedef struct packed {
        logic       initiator_mode;
        logic [6:0] body_bytes;
        logic [7:0] transmit_limit;
        logic [7:0] header_byte;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] time_now;
        logic [7:0]  rx_data;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  radio_cmd;
        logic [2:0]  proto_state;
        logic [7:0]  good_rx_count;
        logic [7:0]  rx_attempt_count;
        logic [7:0]  tx_done_count;
        logic [15:0] length_error_count;
        logic [15:0] header_error_count;
        logic [15:0] crc_error_count;
        logic [15:0] timeout_count;
        logic [6:0]  known_frame_length;
    } rsp_item_t;

    // Output buffer occupancy
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } buf_status_t;

    // Receive window in ticks for a frame length, modulo 2^16
    function automatic logic [15:0] rx_window(input logic [6:0] len);
        return 16'((32'(len) * WIN_SCALE + WIN_BASE) * WIN_TICKS);
    endfunction

    // Report code of the internal state
    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_OFF:   code = PST_OFF;
            ST_WAIT:  code = PST_WAIT;
            ST_RX:    code = PST_RX;
            ST_READY: code = PST_READY;
            ST_TX:    code = PST_TX;
            ST_ABORT: code = PST_ABORT;
            default:  code = PST_OFF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/psc_core.sv -----
// Protocol state machine, frame checks and statistics counters.
`default_nettype none

module psc_core
    import psc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire req_item_t item,
    input  wire logic      fire,
    output rsp_item_t      result
);

    state_t      state_reg, state_next;
    logic [6:0]  fixed_len_reg, fixed_len_next;
    logic [6:0]  cur_len_reg, cur_len_next;
    logic [7:0]  bytes_seen_reg, bytes_seen_next;
    logic [15:0] deadline_reg, deadline_next;
    logic        armed_reg, armed_next;
    logic [7:0]  last_byte_reg, last_byte_next;
    logic [7:0]  rx_good_reg, rx_good_next;
    logic [7:0]  rx_tries_reg, rx_tries_next;
    logic [7:0]  tx_done_reg, tx_done_next;
    logic [15:0] err_reg [ERR_NUM];
    logic [15:0] err_next [ERR_NUM];
    logic [ERR_NUM-1:0] err_inc;
    logic [2:0]  cmd;

    // Next state for one event
    always_comb
    begin
        logic [6:0]  pl;
        logic [7:0]  tx_cnt;
        logic [15:0] since;
        state_next      = state_reg;
        fixed_len_next  = fixed_len_reg;
        cur_len_next    = cur_len_reg;
        bytes_seen_next = bytes_seen_reg;
        deadline_next   = deadline_reg;
        armed_next      = armed_reg;
        last_byte_next  = last_byte_reg;
        rx_good_next    = rx_good_reg;
        rx_tries_next   = rx_tries_reg;
        tx_done_next    = tx_done_reg;
        err_inc         = '0;
        cmd             = CMD_NONE;
        pl = (cfg.body_bytes > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : cfg.body_bytes;
        tx_cnt = tx_done_reg + 8'd1;
        since  = item.time_now - deadline_reg;

        case (item.req_type)
            REQ_START:
            begin
                rx_good_next = '0;
                tx_done_next = '0;
                if (pl != '0)
                begin
                    cur_len_next   = pl + 7'(FRAME_OVERHEAD);
                    fixed_len_next = pl + 7'(FRAME_OVERHEAD);
                end
                else
                begin
                    fixed_len_next = '0;
                end
                if (cfg.initiator_mode && pl != '0)
                begin
                    state_next = ST_READY;
                    cmd        = CMD_TX;
                end
                else
                begin
                    state_next = ST_WAIT;
                    cmd        = CMD_LISTEN;
                end
            end
            REQ_STOP:
            begin
                state_next = ST_OFF;
                cmd        = CMD_OFF;
            end
            REQ_RISE:
            begin
                case (state_reg)
                    ST_WAIT:
                    begin
                        rx_tries_next   = rx_tries_reg + 8'd1;
                        state_next      = ST_RX;
                        bytes_seen_next = '0;
                        last_byte_next  = '0;
                        if (fixed_len_reg != '0)
                        begin
                            deadline_next = item.time_now + rx_window(cur_len_reg);
                            armed_next    = 1'b1;
                        end
                        else
                        begin
                            // length unknown: hold capture time until length byte
                            deadline_next = item.time_now;
                            armed_next    = 1'b0;
                        end
                    end
                    ST_READY: state_next = ST_TX;
                    ST_ABORT: state_next = ST_WAIT;
                    ST_OFF:   state_next = ST_OFF;
                    default:
                    begin
                        state_next = ST_WAIT;
                        cmd        = CMD_RELISTEN;
                    end
                endcase
            end
            REQ_FALL:
            begin
                case (state_reg)
                    ST_RX:
                    begin
                        if (last_byte_reg[CRC_OK_BIT])
                        begin
                            if (rx_good_reg != 8'hFF)
                                rx_good_next = rx_good_reg + 8'd1;
                            if (fixed_len_reg == '0 && bytes_seen_reg != '0)
                                fixed_len_next = cur_len_reg;
                            state_next = ST_WAIT;
                            cmd        = CMD_RELISTEN;
                        end
                        else
                        begin
                            err_inc[ERR_CRC] = 1'b1;
                        end
                    end
                    ST_TX:
                    begin
                        tx_done_next = tx_cnt;
                        if (tx_cnt == cfg.transmit_limit)
                        begin
                            state_next = ST_OFF;
                            cmd        = CMD_OFF;
                        end
                        else
                        begin
                            state_next = ST_READY;
                            cmd        = CMD_TX;
                        end
                    end
                    ST_ABORT: state_next = ST_WAIT;
                    ST_OFF:   state_next = ST_OFF;
                    default:
                    begin
                        state_next = ST_WAIT;
                        cmd        = CMD_RELISTEN;
                    end
                endcase
            end
            REQ_BYTE:
            begin
                if (state_reg == ST_RX)
                begin
                    last_byte_next = item.rx_data;
                    if (bytes_seen_reg == '0)
                    begin
                        // length byte check
                        if ((fixed_len_reg != '0 && item.rx_data != {1'b0, cur_len_reg})
                            || item.rx_data < 8'(FRAME_OVERHEAD)
                            || item.rx_data > 8'(MAX_FRAME))
                        begin
                            state_next       = ST_ABORT;
                            err_inc[ERR_LEN] = 1'b1;
                            cmd              = CMD_RELISTEN;
                        end
                        else
                        begin
                            bytes_seen_next = 8'd1;
                            if (fixed_len_reg == '0)
                            begin
                                cur_len_next  = item.rx_data[6:0];
                                deadline_next = deadline_reg + rx_window(item.rx_data[6:0]);
                                armed_next    = 1'b1;
                            end
                        end
                    end
                    else if (bytes_seen_reg == 8'd1)
                    begin
                        // header byte check
                        if (item.rx_data != cfg.header_byte)
                        begin
                            state_next       = ST_ABORT;
                            err_inc[ERR_HDR] = 1'b1;
                            cmd              = CMD_RELISTEN;
                        end
                        else
                        begin
                            bytes_seen_next = 8'd2;
                        end
                    end
                    else if (bytes_seen_reg != 8'hFF)
                    begin
                        bytes_seen_next = bytes_seen_reg + 8'd1;
                    end
                end
            end
            REQ_TICK:
            begin
                // deadline reached when now - deadline is non-negative mod 2^16
                if (armed_reg && !since[15])
                begin
                    if (state_reg == ST_ABORT)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        if (state_reg == ST_RX)
                        begin
                            state_next       = ST_ABORT;
                            err_inc[ERR_TMO] = 1'b1;
                            cmd              = CMD_RELISTEN;
                        end
                        armed_next = 1'b0;
                    end
                end
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase

        // saturating error counters
        for (int k = 0; k < ERR_NUM; k++)
        begin
            err_next[k] = (err_inc[k] && err_reg[k] != 16'hFFFF) ? err_reg[k] + 16'd1
                                                                   : err_reg[k];
        end
    end

    // Result reflects the state after the event
    always_comb
    begin
        result.radio_cmd          = cmd;
        result.proto_state        = state_code(state_next);
        result.good_rx_count      = rx_good_next;
        result.rx_attempt_count   = rx_tries_next;
        result.tx_done_count      = tx_done_next;
        result.length_error_count = err_next[ERR_LEN];
        result.header_error_count = err_next[ERR_HDR];
        result.crc_error_count    = err_next[ERR_CRC];
        result.timeout_count      = err_next[ERR_TMO];
        result.known_frame_length = fixed_len_next;
    end

    // State update on each transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_OFF;
            fixed_len_reg  <= '0;
            cur_len_reg    <= '0;
            bytes_seen_reg <= '0;
            deadline_reg   <= '0;
            armed_reg      <= 1'b0;
            last_byte_reg  <= '0;
            rx_good_reg    <= '0;
            rx_tries_reg   <= '0;
            tx_done_reg    <= '0;
            for (int k = 0; k < ERR_NUM; k++)
                err_reg[k] <= '0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            fixed_len_reg  <= fixed_len_next;
            cur_len_reg    <= cur_len_next;
            bytes_seen_reg <= bytes_seen_next;
            deadline_reg   <= deadline_next;
            armed_reg      <= armed_next;
            last_byte_reg  <= last_byte_next;
            rx_good_reg    <= rx_good_next;
            rx_tries_reg   <= rx_tries_next;
            tx_done_reg    <= tx_done_next;
            for (int k = 0; k < ERR_NUM; k++)
                err_reg[k] <= err_next[k];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psc_outbuf.sv -----
// Result register with a skid entry so results can wait without blocking input.
`default_nettype none

module psc_outbuf
    import psc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rsp_item_t push_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp,
    output buf_status_t    status
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    rsp_item_t main_reg, main_next;
    rsp_item_t skid_reg, skid_next;
    logic      main_free;

    // Main entry is free when empty or transferring out this cycle
    assign main_free = !main_valid_reg || !rsp_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid         = main_valid_reg;
    assign rsp               = main_reg;
    assign status.main_valid = main_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/packet_strobing_controller.sv -----
// Packet strobing controller top level: input register, protocol core, result buffer.
// Pipeline: two register stages, the input register and then the result buffer.
// Throughput: one event per cycle while req_stall is low; the output skid entry
// lets one result wait while the next event is taken. Configuration writes are
// always ready: cfg_ready is tied high.
// Reset (rst_n, asynchronous, active low): protocol off, counters zero, defaults loaded.
`default_nettype none
`include "packet_strobing_controller_assert.svh"

module packet_strobing_controller
    import psc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_item_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_item_t       rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    req_item_t   s1_item_reg;
    logic        s1_fire;
    rsp_item_t   core_result;
    buf_status_t buf_status;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initiator_mode <= 1'b0;
            cfg_reg.body_bytes     <= '0;
            cfg_reg.transmit_limit <= 8'd1;
            cfg_reg.header_byte    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INITIATOR: cfg_reg.initiator_mode <= cfg_data[0];
                CFG_PAYLOAD:   cfg_reg.body_bytes     <= cfg_data[6:0];
                CFG_TX_LIMIT:  cfg_reg.transmit_limit <= cfg_data;
                CFG_HEADER:    cfg_reg.header_byte    <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: moves on whenever the result buffer has room
    assign s1_fire   = s1_valid_reg && !buf_status.skid_valid;
    assign req_stall = s1_valid_reg && buf_status.skid_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_item_reg <= req;
    end

    psc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (s1_item_reg),
        .fire   (s1_fire),
        .result (core_result)
    );

    psc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_fire),
        .push_data (core_result),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .status    (buf_status)
    );

    // Checks
    `PSC_ASSERT_IMP(a_skid_needs_main, buf_status.skid_valid, buf_status.main_valid)
    `PSC_ASSERT_IMP(a_no_sent_state, rsp_valid, rsp.proto_state != PST_SENT)
    `PSC_ASSERT_IMP(a_frame_len_range, rsp_valid,
        rsp.known_frame_length == 7'd0 || rsp.known_frame_length >= 7'(FRAME_OVERHEAD))
    `PSC_ASSERT_IMP(a_tx_cmd_ready, rsp_valid && rsp.radio_cmd == CMD_TX,
        rsp.proto_state == PST_READY)
    `PSC_ASSERT_NXT(a_fire_fills, s1_fire, rsp_valid)

endmodule

`default_nettype wire
